// File: rtl/cft_pkg.sv
// cft_pkg: shared types and constants for the csv field tokenizer
// used by cft_step and csv_field_tokenizer_unit; no dependencies

package cft_pkg;

    // character codes
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_NUL   = 8'd0;

    // input opcodes
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // result queue depth: room for one two-beat item plus one waiting beat
    localparam int QDEPTH = 3;

    // apb address width and register indexes
    localparam int APB_ADDR_BITS = 3;

    typedef enum logic {
        REG_DELIMITER = 1'b0,
        REG_MULTILINE = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_ROW   = 2'd0,
        PH_QUOTE = 2'd1,
        PH_EOL   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        K_CHAR      = 3'd0,
        K_FIELD     = 3'd1,
        K_FIELD_ROW = 3'd2,
        K_ROW       = 3'd3,
        K_PARSE     = 3'd4
    } kind_t;

    typedef struct packed {
        phase_t phase;
        logic   in_quotes;
        logic   field_has_data;
        logic   row_has_fields;
    } cft_flags_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  char_byte;
        logic [31:0] row_index;
        logic        last;
    } cft_result_t;

endpackage

// File: rtl/csv_field_tokenizer_unit.sv
// csv_field_tokenizer_unit: csv byte tokenizer with apb configuration and result queue
// depends on cft_pkg and cft_step
// a result beat reaches m_* in the cycle after its input beat when the queue is empty
// throughput: one input beat per cycle; an end-of-parse beat that flushes gives two beats
// s_ready drops while the three-entry result queue holds two or more beats
// reset (aresetn low, synchronous): parse state, row counter, queue cleared; comma, multi-line off

module csv_field_tokenizer_unit #(
    parameter int ROW_INDEX_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cft_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // input beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [7:0]                        s_data_byte,
    // result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_kind,
    output logic [7:0]                        m_char_byte,
    output logic [31:0]                       m_row_index,
    output logic                              m_last
);

    localparam int CNT_BITS = $clog2(cft_pkg::QDEPTH + 1);

    logic [7:0]                delim_reg;
    logic                      ml_reg;
    cft_pkg::cft_flags_t       flags_reg;
    cft_pkg::cft_flags_t       flags_next;
    logic [ROW_INDEX_BITS-1:0] row_cnt_reg;
    logic [ROW_INDEX_BITS-1:0] row_cnt_next;
    cft_pkg::cft_result_t      q_reg  [cft_pkg::QDEPTH];
    cft_pkg::cft_result_t      q_next [cft_pkg::QDEPTH];
    logic [CNT_BITS-1:0]       count_reg;
    logic [CNT_BITS-1:0]       count_next;
    logic [CNT_BITS-1:0]       count_pop;
    logic                      res0_valid;
    logic                      res1_valid;
    cft_pkg::cft_result_t      res0;
    cft_pkg::cft_result_t      res1;
    logic                      push;
    logic                      pop;
    logic                      push0;
    logic                      push1;
    logic                      cfg_wr;
    cft_pkg::reg_idx_t         cfg_idx;
    logic [7:0]                wr_delim;

    // configuration port
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = cft_pkg::reg_idx_t'(paddr[2]);
    assign wr_delim = pwdata[7:0];

    always_comb begin
        unique case (cfg_idx)
            cft_pkg::REG_DELIMITER: prdata = {24'd0, delim_reg};
            cft_pkg::REG_MULTILINE: prdata = {31'd0, ml_reg};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= cft_pkg::CH_COMMA;
            ml_reg    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                cft_pkg::REG_DELIMITER: begin
                    // CR, quote and zero are not legal separators
                    if (wr_delim != cft_pkg::CH_CR && wr_delim != cft_pkg::CH_QUOTE &&
                        wr_delim != cft_pkg::CH_NUL) begin
                        delim_reg <= wr_delim;
                    end
                end
                cft_pkg::REG_MULTILINE: ml_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // per-item tokenizer logic
    cft_step #(
        .ROW_INDEX_BITS(ROW_INDEX_BITS)
    ) u_step (
        .opcode           (s_opcode),
        .data_byte        (s_data_byte),
        .delimiter        (delim_reg),
        .multiline_enable (ml_reg),
        .flags            (flags_reg),
        .row_cnt          (row_cnt_reg),
        .flags_next       (flags_next),
        .row_cnt_next     (row_cnt_next),
        .res0_valid       (res0_valid),
        .res1_valid       (res1_valid),
        .res0             (res0),
        .res1             (res1)
    );

    // handshakes; ready leaves room for a two-beat item
    assign s_ready = (count_reg <= CNT_BITS'(1));
    assign m_valid = (count_reg != '0);
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign push0   = push && res0_valid;
    assign push1   = push && res1_valid;

    // result queue: pop shifts toward the head, new beats land after survivors
    always_comb begin
        count_pop  = count_reg - {{(CNT_BITS-1){1'b0}}, pop};
        count_next = count_pop + {{(CNT_BITS-1){1'b0}}, push0} + {{(CNT_BITS-1){1'b0}}, push1};
        for (int i = 0; i < cft_pkg::QDEPTH; i++) begin
            if (pop && i < cft_pkg::QDEPTH - 1) begin
                q_next[i] = q_reg[(i < cft_pkg::QDEPTH - 1) ? i + 1 : i];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (push0 && CNT_BITS'(i) == count_pop) begin
                q_next[i] = res0;
            end
            if (push1 && CNT_BITS'(i) == count_pop + CNT_BITS'(1)) begin
                q_next[i] = res1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            flags_reg   <= '{phase: cft_pkg::PH_ROW, in_quotes: 1'b0,
                             field_has_data: 1'b0, row_has_fields: 1'b0};
            row_cnt_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                flags_reg   <= flags_next;
                row_cnt_reg <= row_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    // head of queue drives the result port
    assign m_kind      = q_reg[0].kind;
    assign m_char_byte = q_reg[0].char_byte;
    assign m_row_index = q_reg[0].row_index;
    assign m_last      = q_reg[0].last;

endmodule

// File: rtl/cft_step.sv
// cft_step: next-state and result logic for one tokenizer input item
// depends on cft_pkg

module cft_step #(
    parameter int ROW_INDEX_BITS = 32
) (
    input  logic                      opcode,
    input  logic [7:0]                data_byte,
    input  logic [7:0]                delimiter,
    input  logic                      multiline_enable,
    input  cft_pkg::cft_flags_t       flags,
    input  logic [ROW_INDEX_BITS-1:0] row_cnt,
    output cft_pkg::cft_flags_t       flags_next,
    output logic [ROW_INDEX_BITS-1:0] row_cnt_next,
    output logic                      res0_valid,
    output logic                      res1_valid,
    output cft_pkg::cft_result_t      res0,
    output cft_pkg::cft_result_t      res1
);

    logic [ROW_INDEX_BITS-1:0] row_inc;
    logic [31:0]               row_now;
    logic [31:0]               row_after;
    logic                      line_end;
    logic                      done;

    assign row_inc  = row_cnt + {{(ROW_INDEX_BITS-1){1'b0}}, 1'b1};
    assign line_end = (data_byte == cft_pkg::CH_CR) || (data_byte == cft_pkg::CH_LF);

    // row counter shown as 32 bits on the result beats
    generate
        if (ROW_INDEX_BITS >= 32) begin : g_trunc
            assign row_now   = row_cnt[31:0];
            assign row_after = row_inc[31:0];
        end else begin : g_ext
            assign row_now   = {{(32-ROW_INDEX_BITS){1'b0}}, row_cnt};
            assign row_after = {{(32-ROW_INDEX_BITS){1'b0}}, row_inc};
        end
    endgenerate

    always_comb begin
        flags_next   = flags;
        row_cnt_next = row_cnt;
        res0_valid   = 1'b0;
        res1_valid   = 1'b0;
        done         = 1'b0;
        res0 = '{kind: cft_pkg::K_CHAR, char_byte: 8'd0, row_index: row_now, last: 1'b1};
        res1 = '{kind: cft_pkg::K_PARSE, char_byte: 8'd0, row_index: row_now, last: 1'b1};

        if (opcode == cft_pkg::OP_FLUSH) begin
            // flush a pending field or row, then report parse end and clear
            if (flags.field_has_data || flags.row_has_fields) begin
                res0.kind      = flags.field_has_data ? cft_pkg::K_FIELD_ROW : cft_pkg::K_ROW;
                res0.last      = 1'b0;
                res0_valid     = 1'b1;
                res1.row_index = row_after;
                res1_valid     = 1'b1;
            end else begin
                res0.kind  = cft_pkg::K_PARSE;
                res0_valid = 1'b1;
            end
            flags_next   = '{phase: cft_pkg::PH_ROW, in_quotes: 1'b0,
                             field_has_data: 1'b0, row_has_fields: 1'b0};
            row_cnt_next = '0;
        end else begin
            // skip line-end runs
            if (flags.phase == cft_pkg::PH_EOL) begin
                if (line_end) begin
                    done = 1'b1;
                end else begin
                    flags_next.phase = cft_pkg::PH_ROW;
                end
            end
            // quote seen inside quotes: doubled quote or close
            if (!done && flags_next.phase == cft_pkg::PH_QUOTE) begin
                flags_next.phase = cft_pkg::PH_ROW;
                if (data_byte == cft_pkg::CH_QUOTE) begin
                    flags_next.field_has_data = 1'b1;
                    res0.char_byte = cft_pkg::CH_QUOTE;
                    res0_valid     = 1'b1;
                    done           = 1'b1;
                end else begin
                    flags_next.in_quotes = 1'b0;
                end
            end
            // row phase
            if (!done) begin
                if (data_byte == delimiter) begin
                    if (flags_next.in_quotes) begin
                        flags_next.field_has_data = 1'b1;
                        res0.char_byte = data_byte;
                    end else begin
                        flags_next.field_has_data = 1'b0;
                        flags_next.row_has_fields = 1'b1;
                        res0.kind = cft_pkg::K_FIELD;
                    end
                    res0_valid = 1'b1;
                end else if (data_byte == cft_pkg::CH_QUOTE) begin
                    if (flags_next.in_quotes) begin
                        flags_next.phase = cft_pkg::PH_QUOTE;
                    end else begin
                        flags_next.in_quotes = 1'b1;
                    end
                end else if (line_end) begin
                    if (flags_next.in_quotes && multiline_enable) begin
                        flags_next.field_has_data = 1'b1;
                        res0.char_byte = data_byte;
                    end else begin
                        res0.kind                 = cft_pkg::K_FIELD_ROW;
                        flags_next.field_has_data = 1'b0;
                        flags_next.row_has_fields = 1'b0;
                        flags_next.in_quotes      = 1'b0;
                        flags_next.phase          = cft_pkg::PH_EOL;
                        row_cnt_next              = row_inc;
                    end
                    res0_valid = 1'b1;
                end else begin
                    flags_next.field_has_data = 1'b1;
                    res0.char_byte = data_byte;
                    res0_valid     = 1'b1;
                end
            end
        end
    end

endmodule

// File: test/csv_field_tokenizer_unit_tb.sv
// csv_field_tokenizer_unit_tb: self-checking testbench for the csv field tokenizer
// drives byte beats and apb register writes, predicts every result beat and checks it
// depends on cft_pkg and csv_field_tokenizer_unit
`timescale 1ns / 100ps

module csv_field_tokenizer_unit_tb;

    localparam int ITEMS_PER_SETTING = 203;
    localparam int HOLD_CYCLES       = 80;
    localparam int WATCHDOG_LIMIT    = 3000;
    localparam int DIRECTED_STEPS    = 25;
    localparam int SETTING_COUNT     = 8;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
    } byte_beat_t;

    typedef struct packed {
        logic            op;
        logic [7:0]      b;
        bit              typed;
        cft_pkg::kind_t  k;
        logic [7:0]      ch;
        logic [31:0]     row;
    } dir_step_t;

    typedef struct packed {
        logic [7:0] delim;
        logic       ml;
    } setting_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [cft_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [31:0]                       pwdata;
    logic [31:0]                       prdata;
    logic                              pready;
    logic                              s_valid;
    logic                              s_ready;
    logic                              s_opcode;
    logic [7:0]                        s_data_byte;
    logic                              m_valid;
    logic                              m_ready;
    logic [2:0]                        m_kind;
    logic [7:0]                        m_char_byte;
    logic [31:0]                       m_row_index;
    logic                              m_last;

    // tokenizer state as the testbench sees it
    cft_pkg::phase_t tok_phase;
    bit              tok_in_quotes;
    bit              tok_field_data;
    bit              tok_row_fields;
    logic [31:0]     tok_row;
    logic [7:0]      cfg_delim;
    bit              cfg_multiline;

    cft_pkg::cft_result_t expected_tokens[$];
    byte_beat_t           plan[$];
    int                   err_count;
    bit                   calm;
    bit                   hold_req;

    // directed walk: typed rows carry their single result beat
    dir_step_t directed_steps [DIRECTED_STEPS] = '{
        '{cft_pkg::OP_DATA,  8'h61,             1'b1, cft_pkg::K_CHAR,  8'h61, 32'd0},
        '{cft_pkg::OP_DATA,  8'h00,             1'b1, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  8'hFF,             1'b1, cft_pkg::K_CHAR,  8'hFF, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_COMMA, 1'b1, cft_pkg::K_FIELD, 8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_QUOTE, 1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_COMMA, 1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_QUOTE, 1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_QUOTE, 1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_CR,    1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_LF,    1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_CR,    1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_QUOTE, 1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_QUOTE, 1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_COMMA, 1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  8'h78,             1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_QUOTE, 1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  8'h79,             1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_QUOTE, 1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  8'h7A,             1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_FLUSH, 8'h00,             1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_FLUSH, 8'hFF,             1'b1, cft_pkg::K_PARSE, 8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_COMMA, 1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_FLUSH, 8'h5A,             1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  cft_pkg::CH_LF,    1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0},
        '{cft_pkg::OP_DATA,  8'h80,             1'b0, cft_pkg::K_CHAR,  8'h00, 32'd0}
    };

    // register settings per random stretch; cr, quote and zero writes must not stick
    setting_t setting_plan [SETTING_COUNT] = '{
        '{8'hFF,             1'b1},
        '{cft_pkg::CH_CR,    1'b0},
        '{8'h01,             1'b1},
        '{cft_pkg::CH_QUOTE, 1'b1},
        '{cft_pkg::CH_LF,    1'b0},
        '{cft_pkg::CH_NUL,   1'b1},
        '{8'h3B,             1'b0},
        '{8'h09,             1'b1}
    };

    csv_field_tokenizer_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_char_byte (m_char_byte),
        .m_row_index (m_row_index),
        .m_last      (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // ---------------- predictor ----------------

    function automatic cft_pkg::cft_result_t make_token(input cft_pkg::kind_t k,
                                                        input logic [7:0] c,
                                                        input logic [31:0] row);
        cft_pkg::cft_result_t t;
        t.kind      = k;
        t.char_byte = c;
        t.row_index = row;
        t.last      = 1'b0;
        return t;
    endfunction

    function automatic void clear_parse();
        tok_phase      = cft_pkg::PH_ROW;
        tok_in_quotes  = 1'b0;
        tok_field_data = 1'b0;
        tok_row_fields = 1'b0;
        tok_row        = '0;
    endfunction

    function automatic void close_row();
        tok_field_data = 1'b0;
        tok_row_fields = 1'b0;
        tok_row        = tok_row + 32'd1;
    endfunction

    function automatic void apply_reg_write(input cft_pkg::reg_idx_t r, input logic [31:0] v);
        case (r)
            cft_pkg::REG_DELIMITER: begin
                if (v[7:0] != cft_pkg::CH_CR && v[7:0] != cft_pkg::CH_QUOTE &&
                    v[7:0] != cft_pkg::CH_NUL) begin
                    cfg_delim = v[7:0];
                end
            end
            cft_pkg::REG_MULTILINE: begin
                cfg_multiline = v[0];
            end
            default: ;
        endcase
    endfunction

    // work out the result beats one accepted input beat causes
    function automatic void predict_tokens(input logic op, input logic [7:0] b,
                                           ref cft_pkg::cft_result_t toks[$]);
        bit line_end;
        bit done;
        toks.delete();
        done = 1'b0;
        line_end = (b == cft_pkg::CH_CR) || (b == cft_pkg::CH_LF);
        if (op == cft_pkg::OP_FLUSH) begin
            // flush a pending field or row, then report the parse end
            if (tok_field_data) begin
                toks.insert(toks.size(), make_token(cft_pkg::K_FIELD_ROW, 8'h00, tok_row));
                close_row();
            end else if (tok_row_fields) begin
                toks.insert(toks.size(), make_token(cft_pkg::K_ROW, 8'h00, tok_row));
                close_row();
            end
            toks.insert(toks.size(), make_token(cft_pkg::K_PARSE, 8'h00, tok_row));
            clear_parse();
            done = 1'b1;
        end
        // skipping the rest of a line-end run
        if (!done && tok_phase == cft_pkg::PH_EOL) begin
            if (line_end) begin
                done = 1'b1;
            end else begin
                tok_phase = cft_pkg::PH_ROW;
            end
        end
        // byte after a quote inside quotes: doubled quote or close
        if (!done && tok_phase == cft_pkg::PH_QUOTE) begin
            tok_phase = cft_pkg::PH_ROW;
            if (b == cft_pkg::CH_QUOTE) begin
                tok_field_data = 1'b1;
                toks.insert(toks.size(), make_token(cft_pkg::K_CHAR, cft_pkg::CH_QUOTE, tok_row));
                done = 1'b1;
            end else begin
                tok_in_quotes = 1'b0;
            end
        end
        // row phase
        if (!done) begin
            if (b == cfg_delim) begin
                if (tok_in_quotes) begin
                    tok_field_data = 1'b1;
                    toks.insert(toks.size(), make_token(cft_pkg::K_CHAR, b, tok_row));
                end else begin
                    tok_field_data = 1'b0;
                    tok_row_fields = 1'b1;
                    toks.insert(toks.size(), make_token(cft_pkg::K_FIELD, 8'h00, tok_row));
                end
            end else if (b == cft_pkg::CH_QUOTE) begin
                if (tok_in_quotes) begin
                    tok_phase = cft_pkg::PH_QUOTE;
                end else begin
                    tok_in_quotes = 1'b1;
                end
            end else if (line_end) begin
                if (tok_in_quotes && cfg_multiline) begin
                    tok_field_data = 1'b1;
                    toks.insert(toks.size(), make_token(cft_pkg::K_CHAR, b, tok_row));
                end else begin
                    toks.insert(toks.size(), make_token(cft_pkg::K_FIELD_ROW, 8'h00, tok_row));
                    close_row();
                    tok_in_quotes = 1'b0;
                    tok_phase = cft_pkg::PH_EOL;
                end
            end else begin
                tok_field_data = 1'b1;
                toks.insert(toks.size(), make_token(cft_pkg::K_CHAR, b, tok_row));
            end
        end
        if (toks.size() > 0) begin
            toks[toks.size() - 1].last = 1'b1;
        end
    endfunction

    // ---------------- stimulus helpers ----------------

    // idle length: none while calm, else mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) begin
            return 0;
        end
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 9) < 7) begin
                c = 8'($urandom_range(32, 126));
            end else begin
                c = 8'($urandom_range(0, 255));
            end
        end while (c == cfg_delim || c == cft_pkg::CH_QUOTE || c == cft_pkg::CH_CR ||
                   c == cft_pkg::CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return cfg_delim;
            1: return cft_pkg::CH_QUOTE;
            2: return cft_pkg::CH_CR;
            3: return cft_pkg::CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void plan_push(input logic op, input logic [7:0] b);
        byte_beat_t p;
        p.op = op;
        p.b  = b;
        plan.insert(plan.size(), p);
    endfunction

    // one well-formed row: plain and quoted fields, then a line end
    function automatic void plan_row();
        int nf;
        int len;
        int f;
        int k;
        int r;
        nf = $urandom_range(1, 4);
        for (f = 0; f < nf; f++) begin
            if (f > 0) begin
                plan_push(cft_pkg::OP_DATA, cfg_delim);
            end
            len = $urandom_range(0, 5);
            if ($urandom_range(0, 2) == 0) begin
                plan_push(cft_pkg::OP_DATA, cft_pkg::CH_QUOTE);
                for (k = 0; k < len; k++) begin
                    r = $urandom_range(0, 19);
                    if (r < 3) begin
                        plan_push(cft_pkg::OP_DATA, cft_pkg::CH_QUOTE);
                        plan_push(cft_pkg::OP_DATA, cft_pkg::CH_QUOTE);
                    end else if (r < 6) begin
                        plan_push(cft_pkg::OP_DATA, cfg_delim);
                    end else if (r < 8) begin
                        plan_push(cft_pkg::OP_DATA, (r == 6) ? cft_pkg::CH_CR : cft_pkg::CH_LF);
                    end else begin
                        plan_push(cft_pkg::OP_DATA, plain_char());
                    end
                end
                plan_push(cft_pkg::OP_DATA, cft_pkg::CH_QUOTE);
            end else begin
                for (k = 0; k < len; k++) begin
                    plan_push(cft_pkg::OP_DATA, plain_char());
                end
            end
        end
        case ($urandom_range(0, 3))
            0: begin
                plan_push(cft_pkg::OP_DATA, cft_pkg::CH_CR);
                plan_push(cft_pkg::OP_DATA, cft_pkg::CH_LF);
            end
            1: plan_push(cft_pkg::OP_DATA, cft_pkg::CH_LF);
            2: plan_push(cft_pkg::OP_DATA, cft_pkg::CH_CR);
            default: begin
                plan_push(cft_pkg::OP_DATA, cft_pkg::CH_CR);
                plan_push(cft_pkg::OP_DATA, cft_pkg::CH_LF);
                plan_push(cft_pkg::OP_DATA, cft_pkg::CH_LF);
            end
        endcase
    endfunction

    // offer one input beat, wait for the handshake, record what it should cause
    task automatic offer_beat(input logic op, input logic [7:0] b, input bit typed,
                              input cft_pkg::cft_result_t typed_res);
        int gap;
        cft_pkg::cft_result_t toks[$];
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid     = 1'b1;
        s_opcode    = op;
        s_data_byte = b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_tokens(op, b, toks);
        if (typed) begin
            expected_tokens.insert(expected_tokens.size(), typed_res);
        end else begin
            foreach (toks[i]) begin
                expected_tokens.insert(expected_tokens.size(), toks[i]);
            end
        end
    endtask

    // ---------------- apb access ----------------

    task automatic apb_write(input cft_pkg::reg_idx_t r, input logic [31:0] v);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = cft_pkg::APB_ADDR_BITS'(int'(r) * 4);
        pwdata  = v;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        apply_reg_write(r, v);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input cft_pkg::reg_idx_t r, output logic [31:0] d);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = cft_pkg::APB_ADDR_BITS'(int'(r) * 4);
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        d = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_registers();
        logic [31:0] d;
        apb_read(cft_pkg::REG_DELIMITER, d);
        if (d[7:0] !== cfg_delim) begin
            note_error($sformatf("delimiter readback: expected %02h, got %02h",
                                 cfg_delim, d[7:0]));
        end
        apb_read(cft_pkg::REG_MULTILINE, d);
        if (d[0] !== cfg_multiline) begin
            note_error($sformatf("multiline readback: expected %0b, got %0b",
                                 cfg_multiline, d[0]));
        end
    endtask

    // drop valid and let every expected beat drain
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_tokens.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random(input int quota);
        int got;
        int r;
        byte_beat_t p;
        got = 0;
        while (got < quota) begin
            if (plan.size() == 0) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    plan_row();
                end else if (r < 92) begin
                    repeat ($urandom_range(1, 3)) plan_push(cft_pkg::OP_DATA, noise_byte());
                end else begin
                    plan_push(cft_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
                end
            end
            p = plan.pop_front();
            offer_beat(p.op, p.b, 1'b0, '0);
            got++;
        end
        plan.delete();
    endtask

    // ---------------- result side ----------------

    // receiver stalls, plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                m_ready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin : watch_results
        cft_pkg::cft_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                note_error($sformatf("unexpected beat: kind %0d char %02h row %0d last %0b",
                                     m_kind, m_char_byte, m_row_index, m_last));
            end else begin
                want = expected_tokens.pop_front();
                if (m_kind !== want.kind || m_char_byte !== want.char_byte ||
                    m_row_index !== want.row_index || m_last !== want.last) begin
                    note_error($sformatf({"beat mismatch: expected kind %0d char %02h ",
                                          "row %0d last %0b, got kind %0d char %02h ",
                                          "row %0d last %0b"},
                                         want.kind, want.char_byte, want.row_index,
                                         want.last, m_kind, m_char_byte, m_row_index,
                                         m_last));
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("csv_field_tokenizer_unit_tb: errors");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial begin
        int p;
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_opcode    = cft_pkg::OP_DATA;
        s_data_byte = 8'h00;
        err_count   = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        cfg_delim     = cft_pkg::CH_COMMA;
        cfg_multiline = 1'b0;
        clear_parse();

        // reset
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset values of the registers, then the directed walk
        check_registers();
        foreach (directed_steps[i]) begin
            offer_beat(directed_steps[i].op, directed_steps[i].b, directed_steps[i].typed,
                       '{directed_steps[i].k, directed_steps[i].ch,
                         directed_steps[i].row, 1'b1});
        end

        // random stretches, one register setting each
        for (p = 0; p < SETTING_COUNT; p++) begin
            wait_idle();
            apb_write(cft_pkg::REG_DELIMITER, {24'($urandom), setting_plan[p].delim});
            apb_write(cft_pkg::REG_MULTILINE, {31'($urandom), setting_plan[p].ml});
            check_registers();
            calm = (p == 2) || (p == 3);
            // long receiver hold-off while the sender keeps pushing
            if (p == 3) begin
                hold_req = 1'b1;
            end
            run_random(ITEMS_PER_SETTING);
            calm = 1'b0;
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (err_count == 0 && expected_tokens.size() == 0) begin
            $display("csv_field_tokenizer_unit_tb: clean");
        end else begin
            $display("csv_field_tokenizer_unit_tb: errors");
        end
        $finish;
    end

endmodule

// File: csv_field_tokenizer_unit.f
rtl/cft_pkg.sv
rtl/cft_step.sv
rtl/csv_field_tokenizer_unit.sv
test/csv_field_tokenizer_unit_tb.sv
